@@ src/hrbp_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, character constants and helper functions for the HTTP request byte parser.
// No dependencies; imported by every module of the block.
package hrbp_pkg;

  localparam int LENGTH_BITS_DEF = 32;
  localparam int OUT_LEN_W       = 32;
  localparam int KEY_LEN         = 14;

  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  typedef enum logic [4:0] {
    ST_START          = 5'd0,
    ST_METHOD         = 5'd1,
    ST_BEFORE_URI     = 5'd2,
    ST_IN_URI         = 5'd3,
    ST_BEFORE_PKEY    = 5'd4,
    ST_IN_PKEY        = 5'd5,
    ST_BEFORE_PVAL    = 5'd6,
    ST_IN_PVAL        = 5'd7,
    ST_BEFORE_PROTO   = 5'd8,
    ST_IN_PROTO       = 5'd9,
    ST_BEFORE_VER     = 5'd10,
    ST_IN_VER         = 5'd11,
    ST_VER_SPLIT      = 5'd12,
    ST_CR             = 5'd13,
    ST_CRLF           = 5'd14,
    ST_CRLFCR         = 5'd15,
    ST_HKEY           = 5'd16,
    ST_H_BEFORE_COLON = 5'd17,
    ST_H_AFTER_COLON  = 5'd18,
    ST_HVAL           = 5'd19,
    ST_BODY           = 5'd20,
    ST_COMPLETE       = 5'd21,
    ST_INVALID        = 5'd22
  } state_e;

  typedef enum logic [3:0] {
    ROLE_DELIM  = 4'd0,
    ROLE_METHOD = 4'd1,
    ROLE_PATH   = 4'd2,
    ROLE_PKEY   = 4'd3,
    ROLE_PVAL   = 4'd4,
    ROLE_PROTO  = 4'd5,
    ROLE_VER    = 4'd6,
    ROLE_HKEY   = 4'd7,
    ROLE_HVAL   = 4'd8,
    ROLE_BODY   = 4'd9
  } role_e;

  typedef enum logic [1:0] {
    VP_SKIP   = 2'd0,
    VP_DIGITS = 2'd1,
    VP_DONE   = 2'd2
  } vphase_e;

  // Commands from the state machine to the length tracker
  typedef struct packed {
    logic key_start;  // first header key byte: clear matcher, then match
    logic key_byte;   // further header key byte
    logic key_end;    // key closed by colon or blank
    logic val_byte;   // header value byte
    logic val_stop;   // header line ended
    logic body_start; // blank line seen
    logic body_byte;  // body byte
  } len_ctl_t;

  // Status from the length tracker to the state machine
  typedef struct packed {
    logic len_nonzero; // a length is present and above zero
    logic body_done;   // this body byte brings the count to the length
  } len_sts_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09);
  endfunction

  function automatic logic is_upper(input logic [7:0] c);
    return c inside {[8'h41:8'h5A]};
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c inside {[8'h41:8'h5A]}) || (c inside {[8'h61:8'h7A]});
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c inside {[8'h09:8'h0D]});
  endfunction

  // "Content-Length", one character per match position
  function automatic logic [7:0] key_char(input logic [3:0] pos);
    logic [7:0] ch;
    case (pos)
      4'd0:    ch = 8'h43; // C
      4'd1:    ch = 8'h6F; // o
      4'd2:    ch = 8'h6E; // n
      4'd3:    ch = 8'h74; // t
      4'd4:    ch = 8'h65; // e
      4'd5:    ch = 8'h6E; // n
      4'd6:    ch = 8'h74; // t
      4'd7:    ch = 8'h2D; // -
      4'd8:    ch = 8'h4C; // L
      4'd9:    ch = 8'h65; // e
      4'd10:   ch = 8'h6E; // n
      4'd11:   ch = 8'h67; // g
      4'd12:   ch = 8'h74; // t
      4'd13:   ch = 8'h68; // h
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

@@ src/hrbp_fsm.sv @@
`timescale 1ns / 1ps
// Next-state logic of the request machine: state, byte role, token end and tracker commands.
// Depends on hrbp_pkg.
module hrbp_fsm (
  input  hrbp_pkg::state_e   state_i,
  input  logic [7:0]         data_i,
  input  hrbp_pkg::len_sts_t sts_i,
  output hrbp_pkg::state_e   state_o,
  output hrbp_pkg::role_e    role_o,
  output logic               closes_o,
  output hrbp_pkg::len_ctl_t ctl_o
);
  import hrbp_pkg::*;

  always_comb begin
    state_o  = state_i;
    role_o   = ROLE_DELIM;
    closes_o = 1'b0;
    ctl_o    = '0;
    case (state_i)
      ST_START: begin
        role_o = ROLE_METHOD;
        if (is_upper(data_i)) state_o = ST_METHOD;
      end
      ST_METHOD: begin
        if (is_blank(data_i)) begin
          state_o  = ST_BEFORE_URI;
          closes_o = 1'b1;
        end else begin
          role_o = ROLE_METHOD;
        end
      end
      ST_BEFORE_URI: begin
        if (data_i == CH_SLASH) begin
          state_o = ST_IN_URI;
          role_o  = ROLE_PATH;
        end
      end
      ST_IN_URI: begin
        if (is_blank(data_i)) begin
          state_o  = ST_BEFORE_PROTO;
          closes_o = 1'b1;
        end else if (data_i == CH_QUEST) begin
          state_o  = ST_BEFORE_PKEY;
          closes_o = 1'b1;
        end else begin
          role_o = ROLE_PATH;
        end
      end
      ST_BEFORE_PKEY: begin
        if (is_blank(data_i) || data_i == CH_CR || data_i == CH_LF) begin
          state_o = ST_INVALID;
        end else begin
          state_o = ST_IN_PKEY;
          role_o  = ROLE_PKEY;
        end
      end
      ST_IN_PKEY: begin
        if (data_i == CH_EQ) begin
          state_o  = ST_BEFORE_PVAL;
          closes_o = 1'b1;
        end else begin
          role_o = ROLE_PKEY;
        end
      end
      ST_BEFORE_PVAL: begin
        if (is_blank(data_i) || data_i == CH_CR || data_i == CH_LF) begin
          state_o = ST_INVALID;
        end else begin
          state_o = ST_IN_PVAL;
          role_o  = ROLE_PVAL;
        end
      end
      ST_IN_PVAL: begin
        if (data_i == CH_AMP) begin
          state_o  = ST_BEFORE_PKEY;
          closes_o = 1'b1;
        end else if (is_blank(data_i)) begin
          state_o  = ST_BEFORE_PROTO;
          closes_o = 1'b1;
        end else begin
          role_o = ROLE_PVAL;
        end
      end
      ST_BEFORE_PROTO: begin
        if (is_alpha(data_i)) begin
          state_o = ST_IN_PROTO;
          role_o  = ROLE_PROTO;
        end
      end
      ST_IN_PROTO: begin
        if (data_i == CH_SLASH) begin
          state_o  = ST_BEFORE_VER;
          closes_o = 1'b1;
        end else begin
          role_o = ROLE_PROTO;
        end
      end
      ST_BEFORE_VER, ST_VER_SPLIT: begin
        if (is_digit(data_i)) begin
          state_o = ST_IN_VER;
          role_o  = ROLE_VER;
        end else begin
          state_o = ST_INVALID;
        end
      end
      ST_IN_VER: begin
        if (data_i == CH_CR) begin
          state_o  = ST_CR;
          closes_o = 1'b1;
        end else begin
          role_o = ROLE_VER;
          if (data_i == CH_DOT) state_o = ST_VER_SPLIT;
        end
      end
      ST_CR: begin
        state_o = (data_i == CH_LF) ? ST_CRLF : ST_INVALID;
      end
      ST_CRLF: begin
        if (is_blank(data_i)) begin
          state_o = ST_INVALID;
        end else if (data_i == CH_CR) begin
          state_o = ST_CRLFCR;
        end else begin
          state_o         = ST_HKEY;
          role_o          = ROLE_HKEY;
          ctl_o.key_start = 1'b1;
        end
      end
      ST_HKEY: begin
        if (data_i == CH_COLON) begin
          state_o       = ST_H_AFTER_COLON;
          closes_o      = 1'b1;
          ctl_o.key_end = 1'b1;
        end else if (is_blank(data_i)) begin
          state_o       = ST_H_BEFORE_COLON;
          closes_o      = 1'b1;
          ctl_o.key_end = 1'b1;
        end else begin
          role_o         = ROLE_HKEY;
          ctl_o.key_byte = 1'b1;
        end
      end
      ST_H_BEFORE_COLON: begin
        if (data_i == CH_COLON) state_o = ST_H_AFTER_COLON;
        else if (!is_blank(data_i)) state_o = ST_INVALID;
      end
      ST_H_AFTER_COLON: begin
        if (!is_blank(data_i)) begin
          state_o        = ST_HVAL;
          role_o         = ROLE_HVAL;
          ctl_o.val_byte = 1'b1;
        end
      end
      ST_HVAL: begin
        if (data_i == CH_CR) begin
          state_o        = ST_CR;
          closes_o       = 1'b1;
          ctl_o.val_stop = 1'b1;
        end else begin
          role_o         = ROLE_HVAL;
          ctl_o.val_byte = 1'b1;
        end
      end
      ST_CRLFCR: begin
        if (data_i == CH_LF) begin
          ctl_o.body_start = 1'b1;
          state_o = sts_i.len_nonzero ? ST_BODY : ST_COMPLETE;
        end
      end
      ST_BODY: begin
        role_o          = ROLE_BODY;
        ctl_o.body_byte = 1'b1;
        if (sts_i.body_done) state_o = ST_COMPLETE;
      end
      default: begin
        state_o = state_i;
      end
    endcase
  end

endmodule

@@ src/hrbp_len.sv @@
`timescale 1ns / 1ps
// Content-Length tracker: key matcher, saturating decimal value parser and body byte counter.
// Depends on hrbp_pkg.
module hrbp_len #(
  parameter int LENGTH_BITS = hrbp_pkg::LENGTH_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          restart_i,
  input  logic [7:0]                    data_i,
  input  hrbp_pkg::len_ctl_t            ctl_i,
  output hrbp_pkg::len_sts_t            sts_o,
  output logic [hrbp_pkg::OUT_LEN_W-1:0] length_o
);
  import hrbp_pkg::*;

  localparam int                     WideW  = LENGTH_BITS + 4;
  localparam logic [LENGTH_BITS-1:0] LenMax = '1;

  logic [3:0]             pos_q, pos_d, pos_c;
  logic                   mism_q, mism_d, mism_c;
  logic                   vil_q, vil_d, vil_c;
  logic                   lp_q, lp_d, lp_c;
  vphase_e                vph_q, vph_d, vph_c;
  logic [LENGTH_BITS-1:0] blen_q, blen_d, blen_c;
  logic [LENGTH_BITS-1:0] bcnt_q, bcnt_d, bcnt_c, bcnt_inc;
  logic [3:0]             pos_b;
  logic                   mism_b;
  logic [WideW-1:0]       blen_ext, blen_mac;
  logic [LENGTH_BITS-1:0] blen_sat;

  // restart clears the tracker before the current byte is applied
  assign pos_c  = restart_i ? '0 : pos_q;
  assign mism_c = restart_i ? 1'b0 : mism_q;
  assign vil_c  = restart_i ? 1'b0 : vil_q;
  assign lp_c   = restart_i ? 1'b0 : lp_q;
  assign vph_c  = restart_i ? VP_SKIP : vph_q;
  assign blen_c = restart_i ? '0 : blen_q;
  assign bcnt_c = restart_i ? '0 : bcnt_q;

  assign pos_b  = ctl_i.key_start ? '0 : pos_c;
  assign mism_b = ctl_i.key_start ? 1'b0 : mism_c;

  // length * 10 + digit, clamped to the all-ones value
  assign blen_ext = {4'b0, blen_c};
  assign blen_mac = (blen_ext << 3) + (blen_ext << 1) + {{LENGTH_BITS{1'b0}}, data_i[3:0]};
  assign blen_sat = (blen_mac > {4'b0, LenMax}) ? LenMax : blen_mac[LENGTH_BITS-1:0];

  assign bcnt_inc = (bcnt_c != LenMax) ? bcnt_c + 1'b1 : bcnt_c;

  assign sts_o.len_nonzero = lp_c && (blen_c != '0);
  assign sts_o.body_done   = bcnt_inc >= blen_c;

  always_comb begin
    pos_d  = pos_c;
    mism_d = mism_c;
    vil_d  = vil_c;
    lp_d   = lp_c;
    vph_d  = vph_c;
    blen_d = blen_c;
    bcnt_d = bcnt_c;

    if (ctl_i.key_start || ctl_i.key_byte) begin
      if (ctl_i.key_start) vil_d = 1'b0;
      if (pos_b < 4'(KEY_LEN) && data_i == key_char(pos_b)) begin
        pos_d  = pos_b + 4'd1;
        mism_d = mism_b;
      end else begin
        pos_d  = pos_b;
        mism_d = 1'b1;
      end
    end

    if (ctl_i.key_end) begin
      vil_d = !mism_c && (pos_c == 4'(KEY_LEN));
      if (vil_d) begin
        lp_d   = 1'b1;
        blen_d = '0;
        vph_d  = VP_SKIP;
      end
    end

    if (ctl_i.val_byte && vil_c && vph_c != VP_DONE) begin
      if (is_digit(data_i)) begin
        blen_d = blen_sat;
        vph_d  = VP_DIGITS;
      end else if (vph_c == VP_SKIP && is_space(data_i)) begin
        vph_d = VP_SKIP;
      end else if (vph_c == VP_SKIP && data_i == CH_PLUS) begin
        vph_d = VP_DIGITS;
      end else if (vph_c == VP_SKIP && data_i == CH_MINUS) begin
        blen_d = '0;
        vph_d  = VP_DONE;
      end else begin
        vph_d = VP_DONE;
      end
    end

    if (ctl_i.val_stop) vil_d = 1'b0;
    if (ctl_i.body_start) bcnt_d = '0;
    if (ctl_i.body_byte) bcnt_d = bcnt_inc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      mism_q <= 1'b0;
      vil_q  <= 1'b0;
      lp_q   <= 1'b0;
      vph_q  <= VP_SKIP;
      blen_q <= '0;
      bcnt_q <= '0;
    end else if (en_i) begin
      pos_q  <= pos_d;
      mism_q <= mism_d;
      vil_q  <= vil_d;
      lp_q   <= lp_d;
      vph_q  <= vph_d;
      blen_q <= blen_d;
      bcnt_q <= bcnt_d;
    end
  end

  // reported length: clamp or widen to the fixed output width
  if (LENGTH_BITS > OUT_LEN_W) begin : g_len_clamp
    assign length_o = (|blen_d[LENGTH_BITS-1:OUT_LEN_W]) ? '1 : blen_d[OUT_LEN_W-1:0];
  end else if (LENGTH_BITS == OUT_LEN_W) begin : g_len_same
    assign length_o = blen_d;
  end else begin : g_len_widen
    assign length_o = {{(OUT_LEN_W - LENGTH_BITS){1'b0}}, blen_d};
  end

endmodule

@@ src/http_request_byte_parser.sv @@
`timescale 1ns / 1ps
// Top level of the HTTP request byte parser: input register, state register, result register.
// Depends on hrbp_pkg, hrbp_fsm and hrbp_len.

// One request byte enters per clock while neither side stalls, and one result leaves per byte,
// in order. A byte is held in an input register. Once the result register is free or being
// emptied, the request machine and the Content-Length tracker update in a single pass, and
// the result is captured in the output register. The sustained rate is one byte per cycle.
// That figure is set by the state update, whose longest path is the length accumulate (times
// ten plus digit, with clamp). Both sides stall independently: when the result is not taken,
// the held byte waits, and the input side closes only once the input register is full. tuser
// carries restart, which returns the machine to its start state before that byte; tlast marks
// the last byte of a chunk and is echoed on the result. Complete and invalid stay until
// restart. A body length wider than 32 bits shows as all ones on the result.
module http_request_byte_parser #(
  parameter int LENGTH_BITS = hrbp_pkg::LENGTH_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  input  logic        s_axis_tuser,  // [0] restart
  input  logic        s_axis_tlast,  // chunk_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // [4:0] parse_state, [8:5] byte_role, [9] closes_token,
                                     // [41:10] length_value, [42] request_ok, [47:43] zero
  output logic        m_axis_tlast   // chunk_done
);
  import hrbp_pkg::*;

  logic                 in_valid_q;
  logic [7:0]           byte_q;
  logic                 restart_q;
  logic                 last_q;
  logic                 adv;

  state_e               state_q, state_c, state_d;
  role_e                role_d;
  logic                 closes_d;
  len_ctl_t             ctl;
  len_sts_t             sts;
  logic [OUT_LEN_W-1:0] len_d;

  logic                 out_valid_q;
  state_e               st_out_q;
  role_e                role_out_q;
  logic                 closes_out_q;
  logic [OUT_LEN_W-1:0] len_out_q;
  logic                 ok_out_q;
  logic                 last_out_q;

  // advance the held request when the result register is free or being emptied
  assign adv           = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      byte_q    <= s_axis_tdata;
      restart_q <= s_axis_tuser;
      last_q    <= s_axis_tlast;
    end
  end

  // restart takes effect before the byte it comes with
  assign state_c = restart_q ? ST_START : state_q;

  hrbp_fsm u_fsm (
    .state_i  (state_c),
    .data_i   (byte_q),
    .sts_i    (sts),
    .state_o  (state_d),
    .role_o   (role_d),
    .closes_o (closes_d),
    .ctl_o    (ctl)
  );

  hrbp_len #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_len (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (adv),
    .restart_i (restart_q),
    .data_i    (byte_q),
    .ctl_i     (ctl),
    .sts_o     (sts),
    .length_o  (len_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_START;
    end else if (adv) begin
      state_q <= state_d;
    end
  end

  // result register: fill on advance, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      st_out_q     <= state_d;
      role_out_q   <= role_d;
      closes_out_q <= closes_d;
      len_out_q    <= len_d;
      ok_out_q     <= (state_d == ST_COMPLETE) || (state_d == ST_BODY);
      last_out_q   <= last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, ok_out_q, len_out_q, closes_out_q, role_out_q, st_out_q};
  assign m_axis_tlast  = last_out_q;

  // request_ok must agree with the reported state
  a_ok_matches_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (ok_out_q == ((st_out_q == ST_COMPLETE) || (st_out_q == ST_BODY))))
    else $error("request_ok disagrees with parse_state");

  // a token end is always a delimiter byte
  a_close_is_delim : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && closes_out_q) |-> (role_out_q == ROLE_DELIM))
    else $error("closing byte carries a token role");

  // complete holds until restart
  a_complete_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && !restart_q && state_q == ST_COMPLETE) |=> (state_q == ST_COMPLETE))
    else $error("complete state left without restart");

  // the input side only closes while a request is held
  a_ready_only_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && out_valid_q))
    else $error("input stalled without a held request");

endmodule
